// File: rtl/rbst_pkg.sv
`default_nettype none

package rbst_pkg;

    // Token kinds as they appear on the result channel
    typedef enum logic [3:0] {
        KIND_ILLEGAL  = 4'd0,
        KIND_ARRAY    = 4'd1,
        KIND_BULKTYPE = 4'd2,
        KIND_SIMPLE   = 4'd3,
        KIND_INT      = 4'd4,
        KIND_ERR      = 4'd5,
        KIND_CR       = 4'd6,
        KIND_LF       = 4'd7,
        KIND_EOF      = 4'd8,
        KIND_BULK     = 4'd9,
        KIND_LEN      = 4'd10
    } token_kind_t;

    // Scanner mode, one-hot
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_TO_CR  = 3'b010,
        MODE_DIGITS = 3'b100
    } scan_mode_t;

    // Protocol bytes
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

    // Queue depth of the result buffer
    localparam int unsigned QUEUE_DEPTH = 3;

    // One result transaction
    typedef struct packed {
        token_kind_t token_kind;
        logic [7:0]  body_byte;
        logic        byte_valid;
        logic        token_done;
        logic        last_of_run;
    } result_t;

    // Results produced by one accepted byte, handed to the result buffer
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } lex_out_t;

endpackage

`default_nettype wire

// File: rtl/rbst_in_if.sv
`default_nettype none

interface rbst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

// File: rtl/rbst_out_if.sv
`default_nettype none

interface rbst_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] token_kind;
    logic [7:0] body_byte;
    logic       byte_valid;
    logic       token_done;
    logic       last_of_run;

    modport source (output valid, output token_kind, output body_byte, output byte_valid,
                    output token_done, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input body_byte, input byte_valid,
                    input token_done, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: rtl/resp_byte_stream_tokenizer_core.sv
`default_nettype none

// Byte-stream tokenizer for a RESP-style protocol. One byte is taken per
// transaction on in_ch and turned into zero, one or two token results on
// out_ch. A new byte is accepted every cycle while the three-entry result
// buffer holds at most one waiting result, so bytes giving at most one
// result each run at one byte per cycle while out_ch.ready is high; a byte
// giving two results (a body end and CR, a new token or the end token)
// fills two entries and can stall the next byte. The first result of a
// byte can leave on the cycle after it is accepted. Body openers '+', ':'
// and '-' produce no result. in_ch.ready depends only on registered state.

module resp_byte_stream_tokenizer_core
    import rbst_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rbst_in_if.sink   in_ch,
    rbst_out_if.source out_ch
);

    lex_out_t lex;
    result_t  res;
    logic     room;
    logic     accept;
    logic     res_valid;

    assign in_ch.ready = room;
    assign accept      = in_ch.valid && room;

    // Byte classification and scanner state
    rbst_lexer u_lexer (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (in_ch.data_byte),
        .end_of_input (in_ch.end_of_input),
        .lex          (lex)
    );

    // Result buffer
    rbst_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .lex       (lex),
        .room      (room),
        .out_valid (res_valid),
        .out_ready (out_ch.ready),
        .out_data  (res)
    );

    assign out_ch.valid       = res_valid;
    assign out_ch.token_kind  = 4'(res.token_kind);
    assign out_ch.body_byte   = res.body_byte;
    assign out_ch.byte_valid  = res.byte_valid;
    assign out_ch.token_done  = res.token_done;
    assign out_ch.last_of_run = res.last_of_run;

endmodule

`default_nettype wire

// File: rtl/rbst_lexer.sv
`default_nettype none

module rbst_lexer
    import rbst_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_input,
    output lex_out_t        lex
);

    typedef struct packed {
        logic        emit;
        result_t     res;
        scan_mode_t  mode;
        token_kind_t kind;
    } class_t;

    scan_mode_t  mode_reg,  mode_next;
    token_kind_t kind_reg,  kind_next;
    class_t      cls;

    function automatic result_t single(input token_kind_t k);
        result_t r;
        r.token_kind  = k;
        r.body_byte   = 8'h00;
        r.byte_valid  = 1'b0;
        r.token_done  = 1'b1;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    function automatic result_t body(input token_kind_t k, input logic [7:0] b);
        result_t r;
        r.token_kind  = k;
        r.body_byte   = b;
        r.byte_valid  = 1'b1;
        r.token_done  = 1'b0;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    function automatic logic digit_char(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    // Classification of a byte seen between tokens
    function automatic class_t classify(input logic [7:0] b);
        class_t c;
        c.emit = 1'b1;
        c.res  = single(KIND_ILLEGAL);
        c.mode = MODE_IDLE;
        c.kind = KIND_ILLEGAL;
        case (b)
            CHAR_STAR:   c.res = single(KIND_ARRAY);
            CHAR_DOLLAR: c.res = single(KIND_BULKTYPE);
            CHAR_PLUS:
            begin
                c.emit = 1'b0;
                c.mode = MODE_TO_CR;
                c.kind = KIND_SIMPLE;
            end
            CHAR_COLON:
            begin
                c.emit = 1'b0;
                c.mode = MODE_TO_CR;
                c.kind = KIND_INT;
            end
            CHAR_MINUS:
            begin
                c.emit = 1'b0;
                c.mode = MODE_TO_CR;
                c.kind = KIND_ERR;
            end
            CHAR_CR:     c.res = single(KIND_CR);
            CHAR_LF:     c.res = single(KIND_LF);
            CHAR_NUL:    c.res = single(KIND_EOF);
            default:
            begin
                if (b inside {[8'h41:8'h5A], [8'h61:8'h7A]})
                begin
                    c.res  = body(KIND_BULK, b);
                    c.mode = MODE_TO_CR;
                    c.kind = KIND_BULK;
                end
                else if (digit_char(b))
                begin
                    c.res  = body(KIND_LEN, b);
                    c.mode = MODE_DIGITS;
                    c.kind = KIND_LEN;
                end
            end
        endcase
        return c;
    endfunction

    // Results and next state for the byte on the input
    always_comb
    begin
        cls          = classify(data_byte);
        mode_next    = mode_reg;
        kind_next    = kind_reg;
        lex.count    = 2'd0;
        lex.first    = single(kind_reg);
        lex.second   = single(KIND_EOF);

        if (end_of_input)
        begin
            mode_next = MODE_IDLE;
            kind_next = KIND_ILLEGAL;
            if (mode_reg == MODE_TO_CR || mode_reg == MODE_DIGITS)
            begin
                lex.count = 2'd2;
            end
            else
            begin
                lex.count = 2'd1;
                lex.first = single(KIND_EOF);
            end
        end
        else
        begin
            case (mode_reg)
                MODE_TO_CR:
                begin
                    if (data_byte == CHAR_CR)
                    begin
                        lex.count  = 2'd2;
                        lex.second = single(KIND_CR);
                        mode_next  = MODE_IDLE;
                        kind_next  = KIND_ILLEGAL;
                    end
                    else
                    begin
                        lex.count = 2'd1;
                        lex.first = body(kind_reg, data_byte);
                    end
                end
                MODE_DIGITS:
                begin
                    if (digit_char(data_byte))
                    begin
                        lex.count = 2'd1;
                        lex.first = body(kind_reg, data_byte);
                    end
                    else
                    begin
                        // close the length body, then classify the ending byte
                        lex.count  = cls.emit ? 2'd2 : 2'd1;
                        lex.second = cls.res;
                        mode_next  = cls.mode;
                        kind_next  = cls.kind;
                    end
                end
                default:
                begin
                    lex.count = {1'b0, cls.emit};
                    lex.first = cls.res;
                    mode_next = cls.mode;
                    kind_next = cls.kind;
                end
            endcase
        end

        // mark the final result of this byte
        if (lex.count == 2'd2)
        begin
            lex.second.last_of_run = 1'b1;
        end
        else
        begin
            lex.first.last_of_run = 1'b1;
        end
    end

    // Scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            kind_reg <= KIND_ILLEGAL;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            kind_reg <= kind_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/rbst_out_queue.sv
`default_nettype none

module rbst_out_queue
    import rbst_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  lex_out_t    lex,
    output logic        room,
    output logic        out_valid,
    input  wire logic   out_ready,
    output result_t     out_data
);

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);

    result_t         mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   wr_ptr_inc;
    logic [PW:0]     count_reg,  count_next;
    logic [1:0]      push_n;
    logic            pop;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Room for a two-result byte, decided from registered state only
    assign room      = (count_reg <= (PW+1)'(QUEUE_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign push_n    = push ? lex.count : 2'd0;
    assign wr_ptr_inc = wrap_inc(wr_ptr_reg);

    // Pointer and fill count update
    always_comb
    begin
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        case (push_n)
            2'd1:    wr_ptr_next = wr_ptr_inc;
            2'd2:    wr_ptr_next = wrap_inc(wr_ptr_inc);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        count_next = count_reg + (PW+1)'(push_n) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= lex.first;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= lex.second;
        end
    end

endmodule

`default_nettype wire

// File: sim/rbst_token_checker.sv
// Watches both channels of the tokenizer, predicts the token results of
// every accepted byte and compares them in order with the results that
// leave the block.
module rbst_token_checker
    import rbst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rbst_in_if          in_mon,
    rbst_out_if         out_mon,
    output int unsigned mismatch_count,
    output int unsigned pending_count,
    output int unsigned result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned REPORT_LIMIT = 10;

    // Character class bounds
    localparam logic [7:0] DIGIT_LO = 8'h30;
    localparam logic [7:0] DIGIT_HI = 8'h39;
    localparam logic [7:0] UPPER_LO = 8'h41;
    localparam logic [7:0] UPPER_HI = 8'h5A;
    localparam logic [7:0] LOWER_LO = 8'h61;
    localparam logic [7:0] LOWER_HI = 8'h7A;

    // Predicted lexer state
    scan_mode_t  lex_mode = MODE_IDLE;
    token_kind_t body_kind = KIND_ILLEGAL;

    // Token results still owed by the block, oldest first
    result_t     expected_tokens[$];

    int unsigned fails = 0;
    int unsigned checked = 0;
    int unsigned step_results = 0;

    function automatic logic digit_char(logic [7:0] b);
        return (b >= DIGIT_LO) && (b <= DIGIT_HI);
    endfunction

    function automatic logic letter_char(logic [7:0] b);
        return ((b >= UPPER_LO) && (b <= UPPER_HI)) || ((b >= LOWER_LO) && (b <= LOWER_HI));
    endfunction

    function automatic void add_result(token_kind_t kind, logic [7:0] b, logic has_byte,
                                       logic done);
        result_t r;
        r.token_kind  = kind;
        r.body_byte   = b;
        r.byte_valid  = has_byte;
        r.token_done  = done;
        r.last_of_run = 1'b0;
        expected_tokens.insert(expected_tokens.size(), r);
        step_results++;
    endfunction

    // Body end result, back to idle
    function automatic void end_body();
        add_result(body_kind, 8'h00, 1'b0, 1'b1);
        lex_mode  = MODE_IDLE;
        body_kind = KIND_ILLEGAL;
    endfunction

    // Byte seen while between tokens
    function automatic void classify_idle_byte(logic [7:0] b);
        case (b)
            CHAR_STAR:   add_result(KIND_ARRAY, 8'h00, 1'b0, 1'b1);
            CHAR_DOLLAR: add_result(KIND_BULKTYPE, 8'h00, 1'b0, 1'b1);
            CHAR_PLUS:
            begin
                lex_mode  = MODE_TO_CR;
                body_kind = KIND_SIMPLE;
            end
            CHAR_COLON:
            begin
                lex_mode  = MODE_TO_CR;
                body_kind = KIND_INT;
            end
            CHAR_MINUS:
            begin
                lex_mode  = MODE_TO_CR;
                body_kind = KIND_ERR;
            end
            CHAR_CR:     add_result(KIND_CR, 8'h00, 1'b0, 1'b1);
            CHAR_LF:     add_result(KIND_LF, 8'h00, 1'b0, 1'b1);
            CHAR_NUL:    add_result(KIND_EOF, 8'h00, 1'b0, 1'b1);
            default:
            begin
                if (letter_char(b))
                begin
                    lex_mode  = MODE_TO_CR;
                    body_kind = KIND_BULK;
                    add_result(KIND_BULK, b, 1'b1, 1'b0);
                end
                else if (digit_char(b))
                begin
                    lex_mode  = MODE_DIGITS;
                    body_kind = KIND_LEN;
                    add_result(KIND_LEN, b, 1'b1, 1'b0);
                end
                else
                begin
                    add_result(KIND_ILLEGAL, 8'h00, 1'b0, 1'b1);
                end
            end
        endcase
    endfunction

    // All results caused by one accepted transaction
    function automatic void tokenize_byte(logic [7:0] b, logic eoi);
        result_t tail;
        step_results = 0;
        if (lex_mode != MODE_TO_CR && lex_mode != MODE_DIGITS)
            lex_mode = MODE_IDLE;

        if (eoi)
        begin
            if (lex_mode != MODE_IDLE)
                end_body();
            add_result(KIND_EOF, 8'h00, 1'b0, 1'b1);
        end
        else if (lex_mode == MODE_TO_CR)
        begin
            if (b == CHAR_CR)
            begin
                end_body();
                add_result(KIND_CR, 8'h00, 1'b0, 1'b1);
            end
            else
            begin
                add_result(body_kind, b, 1'b1, 1'b0);
            end
        end
        else if (lex_mode == MODE_DIGITS)
        begin
            if (digit_char(b))
            begin
                add_result(body_kind, b, 1'b1, 1'b0);
            end
            else
            begin
                end_body();
                classify_idle_byte(b);
            end
        end
        else
        begin
            classify_idle_byte(b);
        end

        // mark the final result of this transaction
        if (step_results > 0)
        begin
            tail = expected_tokens[expected_tokens.size() - 1];
            tail.last_of_run = 1'b1;
            expected_tokens[expected_tokens.size() - 1] = tail;
        end
    endfunction

    function automatic void flag_result(string what, result_t want, result_t got);
        fails++;
        if (fails <= REPORT_LIMIT)
        begin
            $display("%s: expected kind=%0d byte=%02h valid=%0b done=%0b last=%0b",
                     what, want.token_kind, want.body_byte, want.byte_valid,
                     want.token_done, want.last_of_run);
            $display("    got kind=%0d byte=%02h valid=%0b done=%0b last=%0b",
                     got.token_kind, got.body_byte, got.byte_valid,
                     got.token_done, got.last_of_run);
        end
    endfunction

    // Predict on input transactions, compare on output transactions
    always @(posedge clk or negedge rst_n)
    begin : track
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            lex_mode  = MODE_IDLE;
            body_kind = KIND_ILLEGAL;
            expected_tokens.delete();
        end
        else
        begin
            if (in_mon.valid && in_mon.ready)
                tokenize_byte(in_mon.data_byte, in_mon.end_of_input);

            if (out_mon.valid && out_mon.ready)
            begin
                got.token_kind  = token_kind_t'(out_mon.token_kind);
                got.body_byte   = out_mon.body_byte;
                got.byte_valid  = out_mon.byte_valid;
                got.token_done  = out_mon.token_done;
                got.last_of_run = out_mon.last_of_run;
                checked++;
                if (expected_tokens.size() == 0)
                begin
                    flag_result("Unexpected token result", '0, got);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (want.token_kind !== got.token_kind || want.body_byte !== got.body_byte ||
                        want.byte_valid !== got.byte_valid ||
                        want.token_done !== got.token_done ||
                        want.last_of_run !== got.last_of_run)
                        flag_result("Token result mismatch", want, got);
                end
            end
        end
        mismatch_count <= fails;
        pending_count  <= expected_tokens.size();
        result_count   <= checked;
    end

endmodule

// File: sim/resp_byte_stream_tokenizer_core_tb.sv
// Drives byte transactions into the tokenizer and stalls its result side;
// the checker beside the block predicts and compares.
module resp_byte_stream_tokenizer_core_tb
    import rbst_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam time         CLK_PERIOD    = 20ns;
    localparam int unsigned RESET_CYCLES  = 5;
    localparam int unsigned RANDOM_ITEMS  = 1200;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned SETTLE_CYCLES = 16;

    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] LOWER_A    = 8'h61;

    typedef struct {
        logic [7:0] data;
        logic       eoi;
    } stream_item_t;

    logic        clk;
    logic        rst_n;
    logic        hold_request;
    int unsigned mismatch_count;
    int unsigned pending_count;
    int unsigned result_count;

    stream_item_t stream_items[$];
    int unsigned  burst_left;
    int unsigned  eoi_marks;

    rbst_in_if  in_ch();
    rbst_out_if out_ch();

    resp_byte_stream_tokenizer_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    rbst_token_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_mon         (in_ch),
        .out_mon        (out_ch),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .result_count   (result_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Stream building
    function automatic void add_byte(logic [7:0] b);
        stream_item_t it;
        it.data = b;
        it.eoi  = 1'b0;
        stream_items.insert(stream_items.size(), it);
    endfunction

    function automatic void add_eoi();
        stream_item_t it;
        it.data = 8'($urandom_range(0, 255));
        it.eoi  = 1'b1;
        stream_items.insert(stream_items.size(), it);
        eoi_marks++;
    endfunction

    // any byte but CR, so a body keeps running
    function automatic logic [7:0] body_fill();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == CHAR_CR) ? (b ^ 8'h01) : b;
    endfunction

    function automatic logic [7:0] rand_digit();
        return DIGIT_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 1) ? UPPER_A : LOWER_A) + 8'($urandom_range(0, 25));
    endfunction

    // One random protocol message, or noise
    function automatic void add_message();
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            case ($urandom_range(0, 2))
                0:       add_byte(CHAR_PLUS);
                1:       add_byte(CHAR_COLON);
                default: add_byte(CHAR_MINUS);
            endcase
            len = $urandom_range(0, 8);
            repeat (len) add_byte(body_fill());
            add_byte(CHAR_CR);
            add_byte(CHAR_LF);
        end
        else if (pick < 45)
        begin
            // bulk header then letter-led body
            len = $urandom_range(1, 12);
            add_byte(CHAR_DOLLAR);
            if (len > 9)
                add_byte(DIGIT_ZERO + 8'd1);
            add_byte(DIGIT_ZERO + 8'(len % 10));
            add_byte(CHAR_CR);
            add_byte(CHAR_LF);
            add_byte(rand_letter());
            repeat (len - 1) add_byte(body_fill());
            add_byte(CHAR_CR);
            add_byte(CHAR_LF);
        end
        else if (pick < 60)
        begin
            add_byte(CHAR_STAR);
            repeat ($urandom_range(1, 2)) add_byte(rand_digit());
            add_byte(CHAR_CR);
            add_byte(CHAR_LF);
        end
        else if (pick < 70)
        begin
            // digit run ended by an arbitrary byte
            repeat ($urandom_range(1, 6)) add_byte(rand_digit());
            add_byte(8'($urandom_range(0, 255)));
        end
        else if (pick < 76)
        begin
            // end of input, often with a body open
            if ($urandom_range(0, 1))
            begin
                add_byte($urandom_range(0, 1) ? rand_letter() : rand_digit());
                repeat ($urandom_range(0, 3)) add_byte(rand_digit());
            end
            add_eoi();
        end
        else
        begin
            repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    // One input transaction, with bursts and gaps
    task automatic push_item(stream_item_t it);
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
        end
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= it.data;
        in_ch.end_of_input <= it.eoi;
        do @(posedge clk); while (!in_ch.ready);
        burst_left--;
    endtask

    // Sender idles until every predicted result has left the block
    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        burst_left = 0;
    endtask

    // Stimulus and verdict
    initial
    begin : stimulus
        int unsigned idx;
        int unsigned directed_count;
        int unsigned drain_at;
        rst_n              <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.data_byte    <= 8'h00;
        in_ch.end_of_input <= 1'b0;
        hold_request       <= 1'b0;
        burst_left = 0;
        eoi_marks  = 0;

        // directed: single-byte tokens, every body kind, empty body,
        // zero byte inside and ending a body, end of input open and idle
        add_byte(CHAR_STAR);
        add_byte(CHAR_DOLLAR);
        add_byte(CHAR_LF);
        add_byte(CHAR_PLUS);
        add_byte(LOWER_A + 8'd7);
        add_byte(CHAR_NUL);
        add_byte(8'hFF);
        add_byte(CHAR_CR);
        add_byte(CHAR_MINUS);
        add_byte(CHAR_CR);
        add_byte(CHAR_COLON);
        add_byte(DIGIT_ZERO + 8'd7);
        add_byte(CHAR_CR);
        add_byte(DIGIT_ZERO);
        add_byte(DIGIT_ZERO + 8'd9);
        add_byte(CHAR_STAR);
        add_byte(DIGIT_ZERO + 8'd5);
        add_byte(CHAR_NUL);
        add_byte(UPPER_A + 8'd25);
        add_byte(LOWER_A);
        add_eoi();
        add_eoi();
        add_byte(8'h80);
        add_byte(UPPER_A);
        add_byte(CHAR_CR);
        add_byte(DIGIT_ZERO + 8'd3);
        add_eoi();
        directed_count = stream_items.size();

        while (stream_items.size() < directed_count + RANDOM_ITEMS)
            add_message();
        drain_at = directed_count + (stream_items.size() - directed_count) / 2;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (idx = 0; idx < stream_items.size(); idx++)
        begin
            if (idx == directed_count)
                hold_request <= 1'b1;
            push_item(stream_items[idx]);
            if (idx == directed_count - 1 || idx == drain_at)
                wait_for_drain();
        end
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d bytes with %0d end-of-input marks; checked %0d token results",
                 stream_items.size(), eoi_marks, result_count);
        $display("Input in bursts with gaps, output stalled in patterns and one %0d-cycle hold",
                 LONG_HOLD);
        if (mismatch_count == 0 && pending_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Result side: changing stall patterns, one long hold-off on request
    initial
    begin : receiver
        int unsigned pattern;
        int unsigned pattern_left;
        int unsigned tick;
        bit          hold_done;
        pattern      = 0;
        pattern_left = 0;
        tick         = 0;
        hold_done    = 1'b0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (pattern_left == 0)
            begin
                pattern      = $urandom_range(0, 3);
                pattern_left = $urandom_range(16, 200);
            end
            pattern_left--;
            tick++;
            case (pattern)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
                default: out_ch.ready <= tick[1];
            endcase
        end
    end

    // Run limit
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles", cycles);
        $display("Mismatches found");
        $finish;
    end

endmodule
